### rtl/core/ita_pkg.sv
package ita_pkg;

	localparam int MAX_DECIMAL_DIGITS = 20;
	localparam int VALUE_W = 64;
	localparam int BCD_W = 4 * MAX_DECIMAL_DIGITS;
	localparam int CNT_W = 7;

	localparam logic [1:0] KIND_SDEC = 2'd0;
	localparam logic [1:0] KIND_UDEC = 2'd1;
	localparam logic [1:0] KIND_HEX = 2'd2;
	localparam logic [1:0] KIND_HEX_ALT = 2'd3;

	localparam logic [1:0] WSEL_16 = 2'd0;
	localparam logic [1:0] WSEL_32 = 2'd1;
	localparam logic [1:0] WSEL_64 = 2'd2;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_X = 8'h78;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic                hex;
		logic [1:0]          wsel;
		logic                neg;
		logic [VALUE_W-1:0]  mag;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DABBLE,
		ST_PFX_ZERO,
		ST_PFX_X,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} back_state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'b0, d};
		end else begin
			c = 8'h37 + {4'b0, d};
		end
		return c;
	endfunction

endpackage

### rtl/core/ita_front.sv
module ita_front import ita_pkg::*; (
	input  logic                start,
	input  logic [1:0]          kind,
	input  logic [1:0]          width_sel,
	input  logic [VALUE_W-1:0]  value,
	input  q_status_t           q_status,
	output logic                push,
	output item_t               item
);

	logic [VALUE_W-1:0] mask;
	logic [VALUE_W-1:0] v;
	logic               sign_bit;
	logic [1:0]         wsel;

	always_comb begin
		case (width_sel)
			WSEL_16: begin
				wsel = WSEL_16;
				mask = {{(VALUE_W-16){1'b0}}, {16{1'b1}}};
			end
			WSEL_32: begin
				wsel = WSEL_32;
				mask = {{(VALUE_W-32){1'b0}}, {32{1'b1}}};
			end
			default: begin
				wsel = WSEL_64;
				mask = {VALUE_W{1'b1}};
			end
		endcase
		v = value & mask;
		case (wsel)
			WSEL_16: sign_bit = v[15];
			WSEL_32: sign_bit = v[31];
			default: sign_bit = v[VALUE_W-1];
		endcase
		item.hex = kind inside {KIND_HEX, KIND_HEX_ALT};
		item.wsel = wsel;
		item.neg = (kind == KIND_SDEC) && sign_bit;
		item.mag = item.neg ? (~(v | ~mask) + {{(VALUE_W-1){1'b0}}, 1'b1}) : v;
		push = start && !q_status.full;
	end

endmodule

### rtl/core/ita_queue.sv
module ita_queue import ita_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_t     push_item,
	input  logic      pop,
	output item_t     head,
	output q_status_t status
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = mem_q[rd_ptr_q];
	assign status.empty = (count_q == 2'd0);
	assign status.full = (count_q == 2'd2);

endmodule

### rtl/core/ita_back.sv
module ita_back import ita_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      valid,
	output logic [7:0] ascii_char,
	output logic      last
);

	back_state_t        state_q, state_d;
	logic [VALUE_W-1:0] sh_q, sh_d;
	logic [BCD_W-1:0]   bcd_q, bcd_d;
	logic               neg_q, neg_d;
	logic               hex_q, hex_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               valid_q, valid_d;
	logic [7:0]         char_q, char_d;
	logic               last_q, last_d;
	logic [BCD_W-1:0]   bcd_adj;
	logic [3:0]         top;

	always_comb begin
		for (int i = 0; i < MAX_DECIMAL_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	assign top = hex_q ? sh_q[VALUE_W-1 -: 4] : bcd_q[BCD_W-1 -: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			hex_q <= 1'b0;
			sh_q <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			cnt_q <= cnt_d;
			neg_q <= neg_d;
			hex_q <= hex_d;
			sh_q <= sh_d;
		end
	end

	always_ff @(posedge clk) begin
		bcd_q <= bcd_d;
		char_q <= char_d;
		last_q <= last_d;
	end

	always_comb begin
		state_d = state_q;
		sh_d = sh_q;
		bcd_d = bcd_q;
		neg_d = neg_q;
		hex_d = hex_q;
		cnt_d = cnt_q;
		valid_d = 1'b0;
		char_d = char_q;
		last_d = 1'b0;
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					pop = 1'b1;
					hex_d = head.hex;
					neg_d = head.neg;
					if (head.hex) begin
						case (head.wsel)
							WSEL_16: begin
								sh_d = head.mag << (VALUE_W - 16);
								cnt_d = CNT_W'(16 / 4);
							end
							WSEL_32: begin
								sh_d = head.mag << (VALUE_W - 32);
								cnt_d = CNT_W'(32 / 4);
							end
							default: begin
								sh_d = head.mag;
								cnt_d = CNT_W'(VALUE_W / 4);
							end
						endcase
						state_d = ST_PFX_ZERO;
					end else begin
						sh_d = head.mag;
						bcd_d = '0;
						cnt_d = CNT_W'(VALUE_W);
						state_d = ST_DABBLE;
					end
				end
			end
			ST_DABBLE: begin
				bcd_d = {bcd_adj[BCD_W-2:0], sh_q[VALUE_W-1]};
				sh_d = {sh_q[VALUE_W-2:0], 1'b0};
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					cnt_d = CNT_W'(MAX_DECIMAL_DIGITS);
					state_d = neg_q ? ST_SIGN : ST_SKIP;
				end
			end
			ST_PFX_ZERO: begin
				valid_d = 1'b1;
				char_d = CHAR_ZERO;
				state_d = ST_PFX_X;
			end
			ST_PFX_X: begin
				valid_d = 1'b1;
				char_d = CHAR_X;
				state_d = ST_SKIP;
			end
			ST_SIGN: begin
				valid_d = 1'b1;
				char_d = CHAR_MINUS;
				state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (top == 4'd0 && cnt_q > CNT_W'(1)) begin
					sh_d = {sh_q[VALUE_W-5:0], 4'd0};
					bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
					cnt_d = cnt_q - CNT_W'(1);
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				valid_d = 1'b1;
				char_d = digit_char(top);
				last_d = (cnt_q == CNT_W'(1));
				sh_d = {sh_q[VALUE_W-5:0], 4'd0};
				bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign valid = valid_q;
	assign ascii_char = char_q;
	assign last = last_q;

endmodule

### rtl/core/integer_to_ascii_formatter.sv
// Hex output starts with a 0x prefix; decimal runs 64 double-dabble steps, then a minus sign
// if negative. Digits follow with leading zeros skipped, in a scan of all 20 decimal digits.
// A two-entry request queue lets start be taken while a conversion runs, unless busy shows
// the queue full.
// Reset: arst_n clears the queue and sequencer; valid is low out of reset.
// The receiver cannot stall: each character is shown for one cycle with valid.
module integer_to_ascii_formatter import ita_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         kind,
	input  logic [1:0]         width_sel,
	input  logic [VALUE_W-1:0] value,
	output logic               valid,
	output logic [7:0]         ascii_char,
	output logic               last
);

	q_status_t q_status;
	item_t     push_item;
	item_t     head;
	logic      push;
	logic      pop;

	ita_front u_front (
		.start     (start),
		.kind      (kind),
		.width_sel (width_sel),
		.value     (value),
		.q_status  (q_status),
		.push      (push),
		.item      (push_item)
	);

	ita_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ita_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.valid      (valid),
		.ascii_char (ascii_char),
		.last       (last)
	);

	assign busy = q_status.full;

endmodule

### rtl/core/ita_checker.sv
module ita_checker import ita_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic [7:0] ascii_char,
	input logic       last
);

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> valid) else $error("last without valid");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid) else $error("character right after last");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (ascii_char == CHAR_MINUS || ascii_char == CHAR_X) |-> !last)
		else $error("sign or prefix marked last");

	a_prefix_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ascii_char == CHAR_X |-> $past(valid) && $past(ascii_char) == CHAR_ZERO)
		else $error("x not preceded by 0");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (valid),
	.ascii_char (ascii_char),
	.last       (last)
);
